/* sv/rced_pkg.sv */
// Package for the Roberts cross edge detector.
// Holds register indexes, reset values, output mode codes and the square root stage record.
// No dependencies.
`default_nettype none

package rced_pkg;

  // Pixel and configuration widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIM_W  = 12;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUTPUT_MODE  = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 12'd480;
  localparam logic [MODE_W-1:0] MODE_RST   = 2'd2;

  // Output mode codes; any other code gives the magnitude
  localparam logic [MODE_W-1:0] MODE_GX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAG = 2'd2;

  // Square root: 17-bit radicand (255^2 + 255^2), one result bit per cell
  localparam int unsigned SQ_W    = 17;
  localparam int unsigned RT_W    = SQ_W + 1;
  localparam int unsigned N_CELLS = 9;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Record handed from one pipeline cell to the next
  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   rem;
    logic [RT_W-1:0]   root;
    logic [PIX_W-1:0]  gx;
    logic [PIX_W-1:0]  gy;
    logic [MODE_W-1:0] mode;
    logic              fend;
  } sq_stage_t;

endpackage

`default_nettype wire

/* sv/rced_if.sv */
// Stream interfaces of the Roberts cross edge detector: pixel in, edge out, configuration.
// Depends on nothing; widths match rced_pkg.
`default_nettype none

interface rced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rced_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_out;
  logic       frame_end;
  modport source (output valid, output edge_out, output frame_end, input ready);
  modport sink   (input valid, input edge_out, input frame_end, output ready);
endinterface

interface rced_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [11:0] write_data;
  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

/* sv/rced_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
`default_nettype none

module rced_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/rced_sqrt_cell.sv */
// One cell of the integer square root chain: settles one result bit per cycle while en is high.
// Depends on rced_pkg (sq_stage_t, widths).
`default_nettype none

module rced_sqrt_cell import rced_pkg::*; #(
  parameter int unsigned SHIFT = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire sq_stage_t stage_in,
  output sq_stage_t      stage_out
);

  localparam logic [RT_W-1:0] BIT = {{(RT_W-1){1'b0}}, 1'b1} << SHIFT;

  logic [RT_W-1:0] trial;
  logic            take;
  sq_stage_t       stage_nxt;
  sq_stage_t       stage_r;

  // Trial subtract of root + bit
  always_comb begin
    trial     = stage_in.root + BIT;
    take      = ({1'b0, stage_in.rem} >= trial);
    stage_nxt = stage_in;
    if (take) begin
      stage_nxt.rem  = stage_in.rem - trial[SQ_W-1:0];
      stage_nxt.root = (stage_in.root >> 1) + BIT;
    end else begin
      stage_nxt.root = stage_in.root >> 1;
    end
  end

  // Hand the record on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

/* sv/roberts_cross_edge_detector_unit.sv */
// Roberts cross edge detector: one edge pixel per grey pixel, raster order.
// Pipeline: 13 register stages (window, gradient, squares, nine square root cells, output
//   register). Throughput: one pixel per cycle while the output is not stalled, set by the
//   single read and single write per cycle on the line store.
// Reset: synchronous, active low; counters and valid bits clear, registers take their
//   defaults. The line store is not cleared; its data are used only after they were written.
`default_nettype none

module roberts_cross_edge_detector_unit import rced_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rced_in_if.sink   in_ch,
  rced_out_if.source out_ch,
  rced_cfg_if.sink  cfg_ch
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW  = (WW > DIM_W) ? WW : DIM_W;

  // Configuration registers
  logic [DIM_W-1:0]  width_r, height_r;
  logic [MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mode_r   <= MODE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_ch.write_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_ch.write_data;
        REG_OUTPUT_MODE:  mode_r   <= cfg_ch.write_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Pipeline advance: whole chain moves when the output register can take a pixel
  logic out_valid_r;
  logic advance;
  logic in_fire;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign in_fire     = in_ch.valid && advance;

  // Position counters and effective image size
  logic [CW-1:0]    col_r;
  logic [DIM_W-1:0] row_r;
  logic [EW-1:0]    w_ext, w_eff, x_ext, x_eff_ext;
  logic [DIM_W-1:0] h_eff;
  logic [CW-1:0]    x_eff;
  logic             last_col, last_row;

  always_comb begin
    w_ext = EW'(width_r);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff     = (height_r == '0) ? DIM_W'(1) : height_r;
    x_ext     = EW'(col_r);
    // a column past a lowered width ends its row
    x_eff_ext = (x_ext >= w_eff) ? (w_eff - EW'(1)) : x_ext;
    x_eff     = x_eff_ext[CW-1:0];
    last_col  = (x_eff_ext == (w_eff - EW'(1)));
    last_row  = (row_r >= (h_eff - DIM_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : (row_r + DIM_W'(1));
      end else begin
        col_r <= x_eff + CW'(1);
      end
    end
  end

  // Stage A: pixel request registered, line store read under way
  logic             a_v_r;
  logic [PIX_W-1:0] a_pix_r;
  logic [CW-1:0]    a_addr_r;
  logic             a_fcol_r, a_frow_r, a_fend_r;
  logic             a_hit_r;
  logic [PIX_W-1:0] a_byp_r;
  logic [PIX_W-1:0] ram_q;
  logic             ram_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (advance) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r  <= in_ch.pixel_in;
      a_addr_r <= x_eff;
      a_fcol_r <= (x_eff == '0);
      a_frow_r <= (row_r == '0);
      a_fend_r <= last_col && last_row;
      // the previous pixel writes this address in the same cycle (one-pixel rows)
      a_hit_r  <= a_v_r && (a_addr_r == x_eff);
      a_byp_r  <= a_pix_r;
    end
  end

  assign ram_we = a_v_r && advance;

  rced_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_addr_r),
    .wdata (a_pix_r),
    .re    (in_fire),
    .raddr (x_eff),
    .rdata (ram_q)
  );

  // Window and clamped Roberts differences
  logic [PIX_W-1:0] left_r, ul_r;
  logic [PIX_W-1:0] stored, up_pix, left_pix, ul_pix, gx, gy;

  always_comb begin
    stored   = a_hit_r ? a_byp_r : ram_q;
    up_pix   = a_frow_r ? '0 : stored;
    left_pix = a_fcol_r ? '0 : left_r;
    ul_pix   = (a_fcol_r || a_frow_r) ? '0 : ul_r;
    gx       = (ul_pix > a_pix_r) ? (ul_pix - a_pix_r) : '0;
    gy       = (up_pix > left_pix) ? (up_pix - left_pix) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (ram_we) begin
      left_r <= a_pix_r;
      ul_r   <= stored;
    end
  end

  // Stage B: gradients registered
  sq_stage_t b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (advance) begin
      b_r.valid <= a_v_r;
      b_r.rem   <= '0;
      b_r.root  <= '0;
      b_r.gx    <= gx;
      b_r.gy    <= gy;
      b_r.mode  <= mode_r;
      b_r.fend  <= a_fend_r;
    end
  end

  // Stage C: sum of squares
  sq_stage_t c_r;
  sq_stage_t c_nxt;
  logic [2*PIX_W-1:0] sq_x, sq_y;

  assign sq_x = (2*PIX_W)'(b_r.gx) * (2*PIX_W)'(b_r.gx);
  assign sq_y = (2*PIX_W)'(b_r.gy) * (2*PIX_W)'(b_r.gy);

  always_comb begin
    c_nxt     = b_r;
    c_nxt.rem = SQ_W'(sq_x) + SQ_W'(sq_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (advance) begin
      c_r <= c_nxt;
    end
  end

  // Square root chain, one result bit per cell
  sq_stage_t cell_s [N_CELLS+1];

  assign cell_s[0] = c_r;

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    rced_sqrt_cell #(
      .SHIFT (2 * (N_CELLS - 1 - k))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .stage_in  (cell_s[k]),
      .stage_out (cell_s[k+1])
    );
  end

  // Output select and register
  sq_stage_t        last_s;
  logic [PIX_W-1:0] edge_sel;
  logic [PIX_W-1:0] edge_r;
  logic             fend_r;

  assign last_s = cell_s[N_CELLS];

  always_comb begin
    case (last_s.mode)
      MODE_GX:  edge_sel = last_s.gx;
      MODE_GY:  edge_sel = last_s.gy;
      default:  edge_sel = (last_s.root > RT_W'(PIX_MAX)) ? PIX_MAX : last_s.root[PIX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      edge_r <= edge_sel;
      fend_r <= last_s.fend;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.edge_out  = edge_r;
  assign out_ch.frame_end = fend_r;

  // Checks
  a_fend_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_col && last_row) |=> (col_r == '0 && row_r == '0))
    else $error("frame end did not return counters to zero");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(a_v_r) && $stable(col_r) && $stable(row_r)))
    else $error("front end moved during output stall");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(last_s.valid))
    else $error("output valid without a pixel in the last cell");

endmodule

`default_nettype wire
